[design/sixax_pkg.sv]
// ----------------------------------------------------------------------------
// Six-axis offset calibration package
// Shared widths, axis indexes, reset constants and the lane control struct.
// ----------------------------------------------------------------------------
package sixax_pkg;

  localparam int AXES    = 6;
  localparam int RAW_W   = 16;
  localparam int GRAV_W  = 15;

  // axis order: ax, ay, az, gx, gy, gz
  localparam int IDX_AX  = 0;
  localparam int IDX_AY  = 1;
  localparam int IDX_AZ  = 2;
  localparam int IDX_GX  = 3;
  localparam int IDX_GY  = 4;
  localparam int IDX_GZ  = 5;

  // one g in accelerometer counts after reset
  localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd16383;

  // action codes
  localparam logic ACT_MEASURE   = 1'b0;
  localparam logic ACT_CALIBRATE = 1'b1;

  // per-cycle control broadcast to all lanes
  typedef struct packed {
    logic take;    // input transaction accepted this cycle
    logic cal;     // accepted item is a calibration sample
    logic done;    // accepted item closes a calibration run
    logic mul_en;  // load the reciprocal product
    logic upd_en;  // write the new offset
  } lane_ctrl_t;

endpackage

[design/sixax_in_if.sv]
// ----------------------------------------------------------------------------
// Six-axis sample channel
// Valid/ready channel carrying the action flag and six raw sensor words.
// ----------------------------------------------------------------------------
interface sixax_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] accel_x_raw;
  logic [15:0] accel_y_raw;
  logic [15:0] accel_z_raw;
  logic [15:0] gyro_x_raw;
  logic [15:0] gyro_y_raw;
  logic [15:0] gyro_z_raw;

  modport source (
    output valid, action, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  ready
  );

  modport sink (
    input  valid, action, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output ready
  );
endinterface

[design/sixax_out_if.sv]
// ----------------------------------------------------------------------------
// Six-axis result channel
// Valid/ready channel carrying six corrected values and the done flag.
// ----------------------------------------------------------------------------
interface sixax_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x_out;
  logic signed [15:0] accel_y_out;
  logic signed [15:0] accel_z_out;
  logic signed [15:0] gyro_x_out;
  logic signed [15:0] gyro_y_out;
  logic signed [15:0] gyro_z_out;
  logic               cal_done;

  modport source (
    output valid, accel_x_out, accel_y_out, accel_z_out,
           gyro_x_out, gyro_y_out, gyro_z_out, cal_done,
    input  ready
  );

  modport sink (
    input  valid, accel_x_out, accel_y_out, accel_z_out,
           gyro_x_out, gyro_y_out, gyro_z_out, cal_done,
    output ready
  );
endinterface

[design/sixax_lane.sv]
// ----------------------------------------------------------------------------
// Six-axis calibration lane
// One axis: offset subtraction, raw-sample accumulator and the averaging
// divide, done as abs, multiply by a constant reciprocal, then sign and
// gravity correction over three register stages.
// ----------------------------------------------------------------------------
module sixax_lane
  import sixax_pkg::*;
#(
  parameter int CAL_SAMPLES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lane_ctrl_t        ctrl,
  input  logic [RAW_W-1:0]  raw,
  input  logic [GRAV_W-1:0] grav,
  output logic [RAW_W-1:0]  diff
);

  // sum of CAL_SAMPLES signed 16-bit words never overflows this width
  localparam int LOG_N  = $clog2(CAL_SAMPLES);
  localparam int SUM_W  = RAW_W + LOG_N;
  localparam int MAG_W  = SUM_W;
  localparam int SHIFT  = MAG_W + LOG_N;
  localparam int PROD_W = 2 * MAG_W + 1;
  // ceil(2^SHIFT / N): exact floor division for every magnitude below 2^MAG_W
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [MAG_W:0] RCP = RCP_FULL[MAG_W:0];

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [RAW_W-1:0]  offset_r;
  logic [RAW_W-1:0]  offset_nxt;
  logic [MAG_W-1:0]  mag_r;
  logic [MAG_W-1:0]  mag_nxt;
  logic              sign_r;
  logic [PROD_W-1:0] prod_r;
  logic [RAW_W-1:0]  quot;

  // corrected value, wraps mod 2^16
  assign diff = raw - offset_r;

  // accumulate the raw sample, sign extended
  assign sum_nxt = sum_r + {{LOG_N{raw[RAW_W-1]}}, raw};
  assign mag_nxt = sum_nxt[SUM_W-1] ? (~sum_nxt + 1'b1) : sum_nxt;

  // truncate toward zero: divide the magnitude, restore the sign
  assign quot       = prod_r[SHIFT +: RAW_W];
  assign offset_nxt = (sign_r ? (~quot + 1'b1) : quot) - {1'b0, grav};

  // accumulator and offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      offset_r <= '0;
    end else begin
      if (ctrl.take && ctrl.cal) begin
        sum_r <= ctrl.done ? '0 : sum_nxt;
      end
      if (ctrl.upd_en) begin
        offset_r <= offset_nxt;
      end
    end
  end

  // divide pipeline
  always_ff @(posedge clk) begin
    if (ctrl.take && ctrl.done) begin
      mag_r  <= mag_nxt;
      sign_r <= sum_nxt[SUM_W-1];
    end
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(mag_r * RCP);
    end
  end

endmodule

[design/sixax_merge.sv]
// ----------------------------------------------------------------------------
// Six-axis result merge
// Gathers the lane results and the done flag into the output register.
// ----------------------------------------------------------------------------
module sixax_merge
  import sixax_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic                        done,
  input  logic [AXES-1:0][RAW_W-1:0]  diff,
  output logic                        room,
  sixax_out_if.source                 out_s
);

  logic                       valid_r;
  logic [AXES-1:0][RAW_W-1:0] data_r;
  logic                       done_r;

  // register is free when empty or being drained this cycle
  assign room = !valid_r || out_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (out_s.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= diff;
      done_r <= done;
    end
  end

  assign out_s.valid       = valid_r;
  assign out_s.accel_x_out = data_r[IDX_AX];
  assign out_s.accel_y_out = data_r[IDX_AY];
  assign out_s.accel_z_out = data_r[IDX_AZ];
  assign out_s.gyro_x_out  = data_r[IDX_GX];
  assign out_s.gyro_y_out  = data_r[IDX_GY];
  assign out_s.gyro_z_out  = data_r[IDX_GZ];
  assign out_s.cal_done    = done_r;

endmodule

[design/six_axis_offset_calibration_core.sv]
// Each accepted input transaction is written to the output register in the next cycle.
// Throughput: one item per cycle while the output register has room; after the
// item that closes a calibration run, input stalls while the six lane dividers
// (abs, reciprocal multiply, sign/gravity fix) write the new offsets.
// Reset: synchronous active-low rst_n clears offsets, sums, count and valid
// state, and sets the gravity register grav_r to 16383.
// ----------------------------------------------------------------------------
// Six-axis offset calibration core
// Six parallel lanes subtract offsets and accumulate calibration samples; a
// merge stage holds the combined result.
// ----------------------------------------------------------------------------
module six_axis_offset_calibration_core
  import sixax_pkg::*;
#(
  parameter int CAL_SAMPLES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [GRAV_W-1:0] cfg_wdata,
  sixax_in_if.sink          in_s,
  sixax_out_if.source       out_s
);

  localparam int CNT_W = $clog2(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

  logic [GRAV_W-1:0]          grav_r;
  logic [CNT_W-1:0]           count_r;
  logic                       mul_r;
  logic                       upd_r;
  logic                       room;
  logic                       take;
  logic                       is_cal;
  logic                       done;
  lane_ctrl_t                 ctrl;
  logic [AXES-1:0][RAW_W-1:0] raw;
  logic [AXES-1:0][RAW_W-1:0] diff;

  // handshake: hold off while offsets are being rewritten or the output register is full
  assign in_s.ready = room && !mul_r && !upd_r;
  assign take       = in_s.valid && in_s.ready;
  assign is_cal     = (in_s.action == ACT_CALIBRATE);
  assign done       = is_cal && (count_r == CNT_LAST);

  assign ctrl.take   = take;
  assign ctrl.cal    = is_cal;
  assign ctrl.done   = done;
  assign ctrl.mul_en = mul_r;
  assign ctrl.upd_en = upd_r;

  assign raw[IDX_AX] = in_s.accel_x_raw;
  assign raw[IDX_AY] = in_s.accel_y_raw;
  assign raw[IDX_AZ] = in_s.accel_z_raw;
  assign raw[IDX_GX] = in_s.gyro_x_raw;
  assign raw[IDX_GY] = in_s.gyro_y_raw;
  assign raw[IDX_GZ] = in_s.gyro_z_raw;

  // gravity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAVITY_RESET;
    end else if (cfg_we) begin
      grav_r <= cfg_wdata;
    end
  end

  // calibration sample count and divide sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mul_r   <= 1'b0;
      upd_r   <= 1'b0;
    end else begin
      if (take && is_cal) begin
        count_r <= done ? '0 : count_r + 1'b1;
      end
      mul_r <= take && done;
      upd_r <= mul_r;
    end
  end

  // one lane per axis; only z accel removes gravity
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    sixax_lane #(
      .CAL_SAMPLES (CAL_SAMPLES)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .raw   (raw[g]),
      .grav  ((g == IDX_AZ) ? grav_r : '0),
      .diff  (diff[g])
    );
  end

  sixax_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .done  (done),
    .diff  (diff),
    .room  (room),
    .out_s (out_s)
  );

  // a run end walks the divide sequence and then lifts the divide stall on the input
  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    take && done |=> mul_r ##1 upd_r ##1 (!mul_r && !upd_r))
    else $error("divide sequence out of order");

  // every transaction lands in the output register
  a_take_out: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_s.valid)
    else $error("accepted item missing from output");

  // run end carries done out and restarts the count
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    take && done |=> out_s.cal_done && (count_r == '0))
    else $error("run end not flagged or count not cleared");

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Six-axis offset calibration core testbench
// Drives six-axis samples through the valid/ready input channel, predicts the
// corrected values and the calibration done flag, and checks every output
// transaction in order. Covers field extremes, offset wrap at the gravity
// extremes, five full calibration runs (reset gravity, then random gravity) and a
// random noise tail, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_top
  import sixax_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAL_N         = 128;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_RUNS   = 5;
  localparam int NOISE_ITEMS   = 60;

  typedef struct packed {
    logic                        action;
    logic [AXES-1:0][RAW_W-1:0]  raw;
  } sample_t;

  typedef struct packed {
    logic [AXES-1:0][RAW_W-1:0]  corr;
    logic                        done;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [GRAV_W-1:0] cfg_wdata;

  sixax_in_if  in_ch();
  sixax_out_if out_ch();

  six_axis_offset_calibration_core #(
    .CAL_SAMPLES(CAL_N)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_s     (in_ch),
    .out_s    (out_ch)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [GRAV_W-1:0] model_gravity;
  logic [RAW_W-1:0]  model_offset [AXES];
  longint            model_sum [AXES];
  int                model_count;

  result_t expected_corrected [$];

  int  err_count      = 0;
  int  samples_sent   = 0;
  int  results_seen   = 0;
  int  runs_closed    = 0;
  int  gravity_writes = 0;
  int  cycle_count    = 0;
  bit  tx_gaps_on     = 1'b0;
  bit  rx_stalls_on   = 1'b0;

  // Corrects one sample with the current offsets, then folds a calibration
  // sample into the sums and closes the run when the count is reached.
  function automatic result_t correct_and_accumulate(input sample_t s);
    result_t r;
    longint  q;
    int      a;
    r.done = 1'b0;
    for (a = 0; a < AXES; a++) begin
      r.corr[a] = s.raw[a] - model_offset[a];
    end
    if (s.action == ACT_CALIBRATE) begin
      for (a = 0; a < AXES; a++) begin
        model_sum[a] += longint'(signed'(s.raw[a]));
      end
      model_count++;
      if (model_count >= CAL_N) begin
        for (a = 0; a < AXES; a++) begin
          q = model_sum[a] / CAL_N;  // truncates toward zero
          if (a == IDX_AZ) begin
            q -= longint'(model_gravity);
          end
          model_offset[a] = q[RAW_W-1:0];
          model_sum[a]    = 0;
        end
        model_count = 0;
        r.done      = 1'b1;
      end
    end
    return r;
  endfunction

  // mostly short, a few long
  function automatic int gap_length();
    if ($urandom_range(0, 99) < 75) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t uniform_sample(input logic act, input logic [RAW_W-1:0] w);
    sample_t s;
    int      a;
    s.action = act;
    for (a = 0; a < AXES; a++) begin
      s.raw[a] = w;
    end
    return s;
  endfunction

  function automatic sample_t random_sample(input logic act);
    sample_t s;
    int      a;
    s.action = act;
    for (a = 0; a < AXES; a++) begin
      s.raw[a] = RAW_W'($urandom);
    end
    return s;
  endfunction

  // Sends one sample; entered right after a rising edge, returns right after
  // the edge at which the transaction was accepted.
  task automatic push_sample(input sample_t s, output logic closed);
    result_t want;
    int      gap;
    gap = 0;
    if (tx_gaps_on && $urandom_range(0, 99) < 35) begin
      gap = gap_length();
    end
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= s.action;
    in_ch.accel_x_raw <= s.raw[IDX_AX];
    in_ch.accel_y_raw <= s.raw[IDX_AY];
    in_ch.accel_z_raw <= s.raw[IDX_AZ];
    in_ch.gyro_x_raw  <= s.raw[IDX_GX];
    in_ch.gyro_y_raw  <= s.raw[IDX_GY];
    in_ch.gyro_z_raw  <= s.raw[IDX_GZ];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = correct_and_accumulate(s);
    expected_corrected.push_back(want);
    closed = want.done;
    samples_sent++;
    if (want.done) begin
      runs_closed++;
    end
  endtask

  // drop valid and wait until the block has drained
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_corrected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_gravity(input logic [GRAV_W-1:0] g);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we        <= 1'b0;
    model_gravity = g;
    gravity_writes++;
  endtask

  // Finishes the open calibration run with samples at fixed values.
  task automatic finish_run_at(input logic [AXES-1:0][RAW_W-1:0] level);
    sample_t s;
    logic    closed;
    closed   = 1'b0;
    s.action = ACT_CALIBRATE;
    s.raw    = level;
    while (!closed) begin
      push_sample(s, closed);
    end
  endtask

  // ---- test: extremes of every field, both actions ----
  task automatic test_field_extremes();
    logic    closed;
    sample_t s;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    push_sample(uniform_sample(ACT_MEASURE, 16'h0000), closed);
    push_sample(uniform_sample(ACT_MEASURE, 16'hFFFF), closed);
    push_sample(uniform_sample(ACT_MEASURE, 16'h8000), closed);
    push_sample(uniform_sample(ACT_MEASURE, 16'h7FFF), closed);
    push_sample(uniform_sample(ACT_MEASURE, 16'h5555), closed);
    push_sample(uniform_sample(ACT_MEASURE, 16'hAAAA), closed);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    s = uniform_sample(ACT_MEASURE, 16'h0001);
    s.raw[IDX_AZ] = 16'h8000;
    s.raw[IDX_GZ] = 16'h7FFF;
    push_sample(s, closed);
    push_sample(uniform_sample(ACT_CALIBRATE, 16'h7FFF), closed);
    push_sample(uniform_sample(ACT_CALIBRATE, 16'h8000), closed);
    push_sample(uniform_sample(ACT_CALIBRATE, 16'hFFFF), closed);
    push_sample(uniform_sample(ACT_CALIBRATE, 16'h0000), closed);
    push_sample(uniform_sample(ACT_MEASURE, 16'h1234), closed);
  endtask

  // ---- test: z offset wraps at the gravity extremes ----
  task automatic test_offset_wrap();
    logic [AXES-1:0][RAW_W-1:0] level;
    logic                       closed;
    // most negative z with maximum gravity: average minus g leaves the range
    write_gravity(15'h7FFF);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b0;
    level[IDX_AX] = 16'h7FFF;
    level[IDX_AY] = 16'h8000;
    level[IDX_AZ] = 16'h8000;
    level[IDX_GX] = 16'h0000;
    level[IDX_GY] = 16'hFFFF;
    level[IDX_GZ] = 16'h0100;
    finish_run_at(level);
    // completing item used old offsets; these see the new ones
    push_sample(uniform_sample(ACT_MEASURE, 16'h0000), closed);
    push_sample(uniform_sample(ACT_MEASURE, 16'h8000), closed);

    // gravity zero, z at the positive extreme
    write_gravity('0);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    level[IDX_AX] = 16'h8000;
    level[IDX_AZ] = 16'h7FFF;
    level[IDX_GX] = 16'hFFFE;
    finish_run_at(level);
    push_sample(uniform_sample(ACT_MEASURE, 16'hFFFF), closed);
    push_sample(random_sample(ACT_MEASURE), closed);
  endtask

  // ---- test: full runs of noisy samples around random levels ----
  task automatic test_random_runs();
    logic [AXES-1:0][RAW_W-1:0] base;
    sample_t                    s;
    logic                       closed;
    int                         run;
    int                         a;
    int                         amp;
    for (run = 0; run < RANDOM_RUNS; run++) begin
      if (run == 0) begin
        write_gravity(GRAVITY_RESET);
      end else begin
        write_gravity(GRAV_W'($urandom));
      end
      tx_gaps_on   = (run % 3) != 1;
      rx_stalls_on = (run % 3) != 2;
      for (a = 0; a < AXES; a++) begin
        base[a] = RAW_W'($urandom);
      end
      amp = (run == RANDOM_RUNS - 1) ? 32767 : $urandom_range(0, 300);
      closed = 1'b0;
      while (!closed) begin
        if ($urandom_range(0, 99) < 85) begin
          s.action = ACT_CALIBRATE;
          for (a = 0; a < AXES; a++) begin
            s.raw[a] = base[a] + RAW_W'(int'($urandom_range(0, 2 * amp)) - amp);
          end
        end else begin
          s = random_sample(ACT_MEASURE);
        end
        push_sample(s, closed);
      end
      // a few measurements against the fresh offsets
      repeat ($urandom_range(2, 6)) begin
        push_sample(random_sample(ACT_MEASURE), closed);
      end
    end
  endtask

  // ---- test: fully random actions and values, leaves a partial run ----
  task automatic test_noise_tail();
    logic closed;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (NOISE_ITEMS) begin
      push_sample(random_sample(logic'($urandom_range(0, 1))), closed);
    end
  endtask

  // result side: random stalls on ready
  int ready_hold = 0;
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold   = ready_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
      ready_hold   = gap_length() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic compare_field(input string what, input logic [RAW_W-1:0] want,
                               input logic [RAW_W-1:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what,
               $signed(want), $signed(got));
    end
  endtask

  // check each output transaction against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $realtime,
               cycle_count, expected_corrected.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_corrected.size() == 0) begin
        err_count++;
        $display("%0t: unexpected output transaction", $realtime);
      end else begin
        want = expected_corrected.pop_front();
        compare_field("accel_x_out", want.corr[IDX_AX], out_ch.accel_x_out);
        compare_field("accel_y_out", want.corr[IDX_AY], out_ch.accel_y_out);
        compare_field("accel_z_out", want.corr[IDX_AZ], out_ch.accel_z_out);
        compare_field("gyro_x_out",  want.corr[IDX_GX], out_ch.gyro_x_out);
        compare_field("gyro_y_out",  want.corr[IDX_GY], out_ch.gyro_y_out);
        compare_field("gyro_z_out",  want.corr[IDX_GZ], out_ch.gyro_z_out);
        compare_field("cal_done", RAW_W'(want.done), RAW_W'(out_ch.cal_done));
      end
    end
  end

  // main sequence
  initial begin
    int a;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_MEASURE;
    in_ch.accel_x_raw = '0;
    in_ch.accel_y_raw = '0;
    in_ch.accel_z_raw = '0;
    in_ch.gyro_x_raw  = '0;
    in_ch.gyro_y_raw  = '0;
    in_ch.gyro_z_raw  = '0;
    out_ch.ready      = 1'b0;

    model_gravity = GRAVITY_RESET;
    model_count   = 0;
    for (a = 0; a < AXES; a++) begin
      model_offset[a] = '0;
      model_sum[a]    = 0;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_offset_wrap();
    test_random_runs();
    test_noise_tail();

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples, checked %0d results, closed %0d calibration runs.",
             samples_sent, results_seen, runs_closed);
    $display("Gravity register written %0d times; %0d mismatches found.",
             gravity_writes, err_count);
    if (err_count == 0 && expected_corrected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
